>>> rtl/tgm_pkg.sv
// ----------------------------------------------------------------------------
// tgm_pkg
// Shared types and constants for the touch gesture to mouse report converter:
// request, zone and report codes, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tgm_pkg;

    // request codes of one touch sample
    typedef enum logic [1:0] {
        REQ_PRESS   = 2'd0,
        REQ_HELD    = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    // hit zones, codes above the last one map to none
    typedef enum logic [2:0] {
        ZONE_NONE   = 3'd0,
        ZONE_PAD    = 3'd1,
        ZONE_SCROLL = 3'd2,
        ZONE_LEFT   = 3'd3,
        ZONE_RIGHT  = 3'd4
    } zone_t;

    localparam logic [2:0] ZONE_LAST = 3'd4;

    // report kinds
    typedef enum logic [1:0] {
        KIND_MOVE   = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_CLICK  = 2'd2,
        KIND_WHEEL  = 2'd3
    } kind_t;

    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_LEFT  = 2'd1;
    localparam logic [1:0] BTN_RIGHT = 2'd2;

    localparam logic signed [1:0] WHEEL_NONE = 2'sd0;
    localparam logic signed [1:0] WHEEL_UP   = 2'sd1;
    localparam logic signed [1:0] WHEEL_DOWN = -2'sd1;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NUM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MOVE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_SLOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIME    = 3'd5;

    // field and register widths
    localparam int GAIN_W     = 5;
    localparam int MOVE_W     = 10;
    localparam int SLOP_W     = 8;
    localparam int STEP_W     = 8;
    localparam int TAPT_W     = 16;
    localparam int TIME_W     = 32;
    localparam int ZONE_W     = 3;
    localparam int ACC_W      = 13;
    localparam int OUT_MOVE_W = 11;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_NUM_RST    = 5'd1;
    localparam logic [GAIN_W-1:0] GAIN_DEN_RST    = 5'd1;
    localparam logic [MOVE_W-1:0] MAX_MOVE_RST    = 10'd127;
    localparam logic [SLOP_W-1:0] TAP_SLOP_RST    = 8'd10;
    localparam logic [STEP_W-1:0] SCROLL_STEP_RST = 8'd20;
    localparam logic [TAPT_W-1:0] TAP_TIME_RST    = 16'd200;

    // scroll accumulator limits
    localparam int ACC_MAX = 4095;
    localparam int ACC_MIN = -4096;

    // upper bound on results from one sample
    localparam int MAX_RESULTS = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_MOVE,
        ST_WHEEL
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit_press;
        logic commit_held;
        logic commit_release;
        logic commit_clear;
        logic div_start;
        logic div_step;
        logic acc_load;
        logic emit_single;
        logic emit_move;
        logic emit_wheel;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        req_t  req;
        zone_t zone;
        logic  single_emit;
        logic  pad_moves;
        logic  div_done;
        logic  wheel_more;
        logic  out_free;
    } stat_t;

endpackage

>>> rtl/touch_gesture_to_mouse_reports.sv
// ----------------------------------------------------------------------------
// touch_gesture_to_mouse_reports
// Converts touch samples with a pre-computed hit zone into mouse move,
// button, click and wheel reports for a virtual trackpad.
// ----------------------------------------------------------------------------
// One sample is handled at a time. Press, release, clear and still or
// non-pad held samples pass through accept and evaluate. A pad sample
// that moves then goes through the shift-subtract gain divider, which
// retires one quotient bit per cycle over the COORD_BITS+5 bit product,
// both axes in parallel, and then out as a move report. A scroll sample
// gives one wheel report per step, up to min(MAX_WHEEL_PER_ITEM, 32)
// steps. Each report waits while the output register holds an untaken beat.
// Results sit in a single output register, so s_ready returns while the
// last beat of a sample still waits on m_ready. Configuration writes are
// taken in every cycle and must only be issued while the block is idle.
module touch_gesture_to_mouse_reports import tgm_pkg::*; #(
    parameter int COORD_BITS         = 10,
    parameter int MAX_WHEEL_PER_ITEM = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // sample channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic [COORD_BITS-1:0]        s_touch_x,
    input  logic [COORD_BITS-1:0]        s_touch_y,
    input  logic [ZONE_W-1:0]            s_touch_zone,
    input  logic [TIME_W-1:0]            s_time_ms,
    // register write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // report channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_report_kind,
    output logic signed [OUT_MOVE_W-1:0] m_move_x,
    output logic signed [OUT_MOVE_W-1:0] m_move_y,
    output logic [1:0]                   m_button_id,
    output logic                         m_button_down,
    output logic signed [1:0]            m_wheel_dir,
    output logic                         m_last_of_run
);

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencer: idle, evaluate, divide, move out, wheel loop
    tgm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath holds registers, tracking state, divider and output beat
    tgm_dpath #(
        .COORD_BITS         (COORD_BITS),
        .MAX_WHEEL_PER_ITEM (MAX_WHEEL_PER_ITEM)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_req_type    (s_req_type),
        .s_touch_x     (s_touch_x),
        .s_touch_y     (s_touch_y),
        .s_touch_zone  (s_touch_zone),
        .s_time_ms     (s_time_ms),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_report_kind (m_report_kind),
        .m_move_x      (m_move_x),
        .m_move_y      (m_move_y),
        .m_button_id   (m_button_id),
        .m_button_down (m_button_down),
        .m_wheel_dir   (m_wheel_dir),
        .m_last_of_run (m_last_of_run)
    );

endmodule

>>> rtl/tgm_ctrl.sv
// ----------------------------------------------------------------------------
// tgm_ctrl
// Sequencing state machine: takes one sample, picks the action for it and
// steps the datapath through division and wheel emission.
// ----------------------------------------------------------------------------
module tgm_ctrl import tgm_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                case (stat.req)
                    REQ_PRESS: begin
                        if (!stat.single_emit || stat.out_free) begin
                            cmd.commit_press = 1'b1;
                            cmd.emit_single  = stat.single_emit;
                            state_next       = ST_IDLE;
                        end
                    end
                    REQ_RELEASE: begin
                        if (!stat.single_emit || stat.out_free) begin
                            cmd.commit_release = 1'b1;
                            cmd.emit_single    = stat.single_emit;
                            state_next         = ST_IDLE;
                        end
                    end
                    REQ_HELD: begin
                        case (stat.zone)
                            ZONE_NONE: begin
                                state_next = ST_IDLE;
                            end
                            ZONE_PAD: begin
                                cmd.commit_held = 1'b1;
                                if (stat.pad_moves) begin
                                    cmd.div_start = 1'b1;
                                    state_next    = ST_DIV;
                                end else begin
                                    state_next = ST_IDLE;
                                end
                            end
                            ZONE_SCROLL: begin
                                cmd.commit_held = 1'b1;
                                cmd.acc_load    = 1'b1;
                                state_next      = ST_WHEEL;
                            end
                            default: begin
                                cmd.commit_held = 1'b1;
                                state_next      = ST_IDLE;
                            end
                        endcase
                    end
                    default: begin
                        cmd.commit_clear = 1'b1;
                        state_next       = ST_IDLE;
                    end
                endcase
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_MOVE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_MOVE: begin
                if (stat.out_free) begin
                    cmd.emit_move = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_WHEEL: begin
                if (!stat.wheel_more) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.emit_wheel = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/tgm_dpath.sv
// ----------------------------------------------------------------------------
// tgm_dpath
// Datapath: configuration registers, sample capture, tracking state,
// shift-subtract gain divider, scroll accumulator and output register.
// ----------------------------------------------------------------------------
module tgm_dpath import tgm_pkg::*; #(
    parameter int COORD_BITS         = 10,
    parameter int MAX_WHEEL_PER_ITEM = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cmd_t                         cmd,
    output stat_t                        stat,
    input  logic [1:0]                   s_req_type,
    input  logic [COORD_BITS-1:0]        s_touch_x,
    input  logic [COORD_BITS-1:0]        s_touch_y,
    input  logic [ZONE_W-1:0]            s_touch_zone,
    input  logic [TIME_W-1:0]            s_time_ms,
    input  logic                         cfg_valid,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_report_kind,
    output logic signed [OUT_MOVE_W-1:0] m_move_x,
    output logic signed [OUT_MOVE_W-1:0] m_move_y,
    output logic [1:0]                   m_button_id,
    output logic                         m_button_down,
    output logic signed [1:0]            m_wheel_dir,
    output logic                         m_last_of_run
);

    localparam int DELTA_W     = COORD_BITS + 1;
    localparam int PROD_W      = COORD_BITS + GAIN_W;
    localparam int DCNT_W      = $clog2(PROD_W + 1);
    localparam int WHEEL_LIMIT = (MAX_WHEEL_PER_ITEM < MAX_RESULTS) ?
                                 MAX_WHEEL_PER_ITEM : MAX_RESULTS;
    localparam int WCNT_W      = $clog2(WHEEL_LIMIT + 1);
    localparam int SUM_W       = ((DELTA_W > ACC_W) ? DELTA_W : ACC_W) + 1;
    localparam int STEPX_W     = ACC_W + 1;

    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(ACC_MAX);
    localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(ACC_MIN);

    function automatic logic step_due(input logic signed [STEPX_W-1:0] a,
                                      input logic signed [STEPX_W-1:0] s);
        return (a >= s) || (a <= -s);
    endfunction

    // configuration registers
    logic [GAIN_W-1:0] gain_num_reg;
    logic [GAIN_W-1:0] gain_den_reg;
    logic [MOVE_W-1:0] max_move_reg;
    logic [SLOP_W-1:0] tap_slop_reg;
    logic [STEP_W-1:0] scroll_step_reg;
    logic [TAPT_W-1:0] tap_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_num_reg    <= GAIN_NUM_RST;
            gain_den_reg    <= GAIN_DEN_RST;
            max_move_reg    <= MAX_MOVE_RST;
            tap_slop_reg    <= TAP_SLOP_RST;
            scroll_step_reg <= SCROLL_STEP_RST;
            tap_time_reg    <= TAP_TIME_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GAIN_NUM:    gain_num_reg    <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_DEN:    gain_den_reg    <= cfg_data[GAIN_W-1:0];
                CFG_MAX_MOVE:    max_move_reg    <= cfg_data[MOVE_W-1:0];
                CFG_TAP_SLOP:    tap_slop_reg    <= cfg_data[SLOP_W-1:0];
                CFG_SCROLL_STEP: scroll_step_reg <= cfg_data[STEP_W-1:0];
                CFG_TAP_TIME:    tap_time_reg    <= cfg_data[TAPT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // captured sample
    req_t                  req_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    zone_t                 zone_in_reg;
    logic [TIME_W-1:0]     time_reg;
    zone_t                 zone_in;

    assign zone_in = (s_touch_zone > ZONE_LAST) ? ZONE_NONE : zone_t'(s_touch_zone);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg     <= req_t'(s_req_type);
            x_reg       <= s_touch_x;
            y_reg       <= s_touch_y;
            zone_in_reg <= zone_in;
            time_reg    <= s_time_ms;
        end
    end

    // tracking state
    zone_t                    active_zone_reg;
    logic [COORD_BITS-1:0]    last_x_reg;
    logic [COORD_BITS-1:0]    last_y_reg;
    logic [COORD_BITS-1:0]    start_x_reg;
    logic [COORD_BITS-1:0]    start_y_reg;
    logic [TIME_W-1:0]        start_time_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     moved_reg;
    logic [WCNT_W-1:0]        wcnt_reg;

    // deltas from the last position
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;

    assign dx = $signed({1'b0, x_reg}) - $signed({1'b0, last_x_reg});
    assign dy = $signed({1'b0, y_reg}) - $signed({1'b0, last_y_reg});

    // distance from the start point against the slop
    logic [COORD_BITS-1:0] dist_x;
    logic [COORD_BITS-1:0] dist_y;
    logic                  far;

    assign dist_x = (x_reg >= start_x_reg) ? x_reg - start_x_reg : start_x_reg - x_reg;
    assign dist_y = (y_reg >= start_y_reg) ? y_reg - start_y_reg : start_y_reg - y_reg;
    assign far    = (dist_x > COORD_BITS'(tap_slop_reg)) ||
                    (dist_y > COORD_BITS'(tap_slop_reg));

    // tap window, modulo 2^32
    logic [TIME_W-1:0] elapsed;
    logic              tap_ok;

    assign elapsed = time_reg - start_time_reg;
    assign tap_ok  = elapsed < TIME_W'(tap_time_reg);

    // scroll accumulator arithmetic
    logic [STEP_W-1:0]          step_eff;
    logic signed [STEPX_W-1:0]  stepx;
    logic signed [STEPX_W-1:0]  accx;
    logic signed [STEPX_W-1:0]  acc_after;
    logic                       wheel_down;
    logic                       wheel_last;
    logic signed [SUM_W-1:0]    acc_sum;
    logic signed [ACC_W-1:0]    acc_sat;

    assign step_eff   = (scroll_step_reg == '0) ? STEP_W'(1) : scroll_step_reg;
    assign stepx      = $signed(STEPX_W'(step_eff));
    assign accx       = $signed({acc_reg[ACC_W-1], acc_reg});
    assign wheel_down = accx >= stepx;
    assign acc_after  = wheel_down ? accx - stepx : accx + stepx;
    assign wheel_last = (wcnt_reg == WCNT_W'(WHEEL_LIMIT - 1)) ||
                        !step_due(acc_after, stepx);
    assign acc_sum    = $signed({{(SUM_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg}) +
                        $signed({{(SUM_W-DELTA_W){dy[DELTA_W-1]}}, dy});

    always_comb begin
        if (acc_sum > SUM_HI) begin
            acc_sat = ACC_W'(ACC_MAX);
        end else if (acc_sum < SUM_LO) begin
            acc_sat = ACC_W'(ACC_MIN);
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_zone_reg <= ZONE_NONE;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            start_time_reg  <= '0;
            acc_reg         <= '0;
            moved_reg       <= 1'b0;
            wcnt_reg        <= '0;
        end else begin
            if (cmd.commit_press) begin
                active_zone_reg <= zone_in_reg;
                last_x_reg      <= x_reg;
                last_y_reg      <= y_reg;
                start_x_reg     <= x_reg;
                start_y_reg     <= y_reg;
                start_time_reg  <= time_reg;
                acc_reg         <= '0;
                moved_reg       <= 1'b0;
            end
            if (cmd.commit_held) begin
                last_x_reg <= x_reg;
                last_y_reg <= y_reg;
                if (active_zone_reg == ZONE_PAD && far) begin
                    moved_reg <= 1'b1;
                end
            end
            if (cmd.commit_release) begin
                active_zone_reg <= ZONE_NONE;
            end
            if (cmd.commit_clear) begin
                active_zone_reg <= ZONE_NONE;
                acc_reg         <= '0;
                moved_reg       <= 1'b0;
            end
            if (cmd.acc_load) begin
                acc_reg  <= acc_sat;
                wcnt_reg <= '0;
            end
            if (cmd.emit_wheel) begin
                acc_reg  <= acc_after[ACC_W-1:0];
                wcnt_reg <= wcnt_reg + WCNT_W'(1);
            end
        end
    end

    // gain divider, one quotient bit per cycle in each lane
    logic [GAIN_W-1:0]  den_eff;
    logic [PROD_W-1:0]  dvd_reg [2];
    logic [GAIN_W-1:0]  rem_reg [2];
    logic               neg_reg [2];
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [PROD_W-1:0]  prod    [2];
    logic [DELTA_W-1:0] mag_d   [2];
    logic [GAIN_W:0]    trial   [2];
    logic               ge      [2];

    assign den_eff = (gain_den_reg == '0) ? GAIN_W'(1) : gain_den_reg;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            mag_d[i] = (i == 0) ? (dx[DELTA_W-1] ? -dx : dx) : (dy[DELTA_W-1] ? -dy : dy);
            prod[i]  = PROD_W'(mag_d[i][COORD_BITS-1:0]) * PROD_W'(gain_num_reg);
            trial[i] = {rem_reg[i], dvd_reg[i][PROD_W-1]};
            ge[i]    = trial[i] >= {1'b0, den_eff};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            dcnt_reg <= DCNT_W'(PROD_W);
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 2; i++) begin
            if (cmd.div_start) begin
                dvd_reg[i] <= prod[i];
                rem_reg[i] <= '0;
                neg_reg[i] <= (i == 0) ? dx[DELTA_W-1] : dy[DELTA_W-1];
            end else if (cmd.div_step) begin
                rem_reg[i] <= ge[i] ? GAIN_W'(trial[i] - {1'b0, den_eff})
                                    : trial[i][GAIN_W-1:0];
                dvd_reg[i] <= {dvd_reg[i][PROD_W-2:0], ge[i]};
            end
        end
    end

    // clamp and sign of the quotients
    logic [MOVE_W-1:0]            mag_cl [2];
    logic signed [OUT_MOVE_W-1:0] mv     [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            mag_cl[i] = (dvd_reg[i] > PROD_W'(max_move_reg)) ? max_move_reg
                                                              : dvd_reg[i][MOVE_W-1:0];
            mv[i]     = neg_reg[i] ? -$signed({1'b0, mag_cl[i]}) : $signed({1'b0, mag_cl[i]});
        end
    end

    // press and release reports
    logic       single_emit;
    kind_t      single_kind;
    logic [1:0] single_id;
    logic       single_down;

    always_comb begin
        single_emit = 1'b0;
        single_kind = KIND_BUTTON;
        single_id   = BTN_NONE;
        single_down = 1'b0;
        case (req_reg)
            REQ_PRESS: begin
                single_emit = (zone_in_reg == ZONE_LEFT) || (zone_in_reg == ZONE_RIGHT);
                single_id   = (zone_in_reg == ZONE_LEFT) ? BTN_LEFT : BTN_RIGHT;
                single_down = 1'b1;
            end
            REQ_RELEASE: begin
                if (active_zone_reg == ZONE_PAD) begin
                    single_emit = !moved_reg && tap_ok;
                    single_kind = KIND_CLICK;
                    single_id   = BTN_LEFT;
                end else begin
                    single_emit = (active_zone_reg == ZONE_LEFT) ||
                                  (active_zone_reg == ZONE_RIGHT);
                    single_id   = (active_zone_reg == ZONE_LEFT) ? BTN_LEFT : BTN_RIGHT;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    logic                         m_valid_reg;
    kind_t                        kind_reg;
    logic signed [OUT_MOVE_W-1:0] move_x_reg;
    logic signed [OUT_MOVE_W-1:0] move_y_reg;
    logic [1:0]                   button_id_reg;
    logic                         button_down_reg;
    logic signed [1:0]            wheel_dir_reg;
    logic                         last_reg;
    logic                         out_free;
    logic                         any_emit;

    assign out_free = !m_valid_reg || m_ready;
    assign any_emit = cmd.emit_single || cmd.emit_move || cmd.emit_wheel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (any_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_single) begin
            kind_reg        <= single_kind;
            move_x_reg      <= '0;
            move_y_reg      <= '0;
            button_id_reg   <= single_id;
            button_down_reg <= single_down;
            wheel_dir_reg   <= WHEEL_NONE;
            last_reg        <= 1'b1;
        end else if (cmd.emit_move) begin
            kind_reg        <= KIND_MOVE;
            move_x_reg      <= mv[0];
            move_y_reg      <= mv[1];
            button_id_reg   <= BTN_NONE;
            button_down_reg <= 1'b0;
            wheel_dir_reg   <= WHEEL_NONE;
            last_reg        <= 1'b1;
        end else if (cmd.emit_wheel) begin
            kind_reg        <= KIND_WHEEL;
            move_x_reg      <= '0;
            move_y_reg      <= '0;
            button_id_reg   <= BTN_NONE;
            button_down_reg <= 1'b0;
            wheel_dir_reg   <= wheel_down ? WHEEL_DOWN : WHEEL_UP;
            last_reg        <= wheel_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_report_kind = kind_reg;
    assign m_move_x      = move_x_reg;
    assign m_move_y      = move_y_reg;
    assign m_button_id   = button_id_reg;
    assign m_button_down = button_down_reg;
    assign m_wheel_dir   = wheel_dir_reg;
    assign m_last_of_run = last_reg;

    // status back to the controller
    assign stat.req         = req_reg;
    assign stat.zone        = active_zone_reg;
    assign stat.single_emit = single_emit;
    assign stat.pad_moves   = (x_reg != last_x_reg) || (y_reg != last_y_reg);
    assign stat.div_done    = (dcnt_reg == '0);
    assign stat.wheel_more  = (wcnt_reg != WCNT_W'(WHEEL_LIMIT)) && step_due(accx, stepx);
    assign stat.out_free    = out_free;

`ifndef SYNTHESIS
    // a beat is only loaded into the output register when it is free
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        any_emit |-> out_free)
        else $error("report loaded over a pending beat");

    a_emit_one: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_single, cmd.emit_move, cmd.emit_wheel}))
        else $error("more than one report source in a cycle");

    a_wheel_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        wcnt_reg <= WCNT_W'(WHEEL_LIMIT))
        else $error("wheel step count beyond limit");

    a_wheel_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_reg == KIND_WHEEL) |->
            (wheel_dir_reg == WHEEL_UP || wheel_dir_reg == WHEEL_DOWN))
        else $error("wheel report without direction");

    a_div_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (dcnt_reg != '0) |-> !any_emit)
        else $error("report emitted while division in progress");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the touch gesture to mouse report converter. A
// queue-fed driver offers touch samples, a clocked monitor predicts the
// reports of every accepted sample and compares each report beat field by
// field, over several register settings and three idling regimes.
// ----------------------------------------------------------------------------
module tb import tgm_pkg::*;;

    localparam int COORD_BITS     = 10;
    localparam int WHEEL_PER_ITEM = 32;
    // wheel steps one sample can give
    localparam int WHEEL_CAP      = (WHEEL_PER_ITEM < MAX_RESULTS) ? WHEEL_PER_ITEM
                                                                    : MAX_RESULTS;
    // quiet cycles after the last report
    localparam int SETTLE_CYCLES  = 64;
    localparam int CYCLE_LIMIT    = 1_500_000;

    typedef struct packed {
        req_t                  req;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [ZONE_W-1:0]     zone;
        logic [TIME_W-1:0]     stamp;
    } touch_t;

    typedef struct packed {
        kind_t                        kind;
        logic signed [OUT_MOVE_W-1:0] mx;
        logic signed [OUT_MOVE_W-1:0] my;
        logic [1:0]                   bid;
        logic                         down;
        logic signed [1:0]            wheel;
        logic                         last;
    } report_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [1:0]                   s_req_type;
    logic [COORD_BITS-1:0]        s_touch_x;
    logic [COORD_BITS-1:0]        s_touch_y;
    logic [ZONE_W-1:0]            s_touch_zone;
    logic [TIME_W-1:0]            s_time_ms;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data  = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [1:0]                   m_report_kind;
    logic signed [OUT_MOVE_W-1:0] m_move_x;
    logic signed [OUT_MOVE_W-1:0] m_move_y;
    logic [1:0]                   m_button_id;
    logic                         m_button_down;
    logic signed [1:0]            m_wheel_dir;
    logic                         m_last_of_run;

    // sample on the input channel, payload ports follow it
    touch_t offered = '0;
    logic   s_fire  = 1'b0;

    touch_t  sample_q[$];   // samples still to be offered
    report_t report_q[$];   // reports predicted but not yet seen
    report_t want_report;

    int send_idle_pct = 19;
    int recv_idle_pct = 81;
    int mismatches    = 0;
    int beats_seen    = 0;
    int cycles        = 0;

    // long receiver hold-off, requested by the sequence, timed by the receiver
    logic hold_off_go   = 1'b0;
    logic hold_off_done = 1'b0;
    int   hold_left     = 0;

    // register copies
    logic [GAIN_W-1:0] gain_num    = GAIN_NUM_RST;
    logic [GAIN_W-1:0] gain_den    = GAIN_DEN_RST;
    logic [MOVE_W-1:0] max_move    = MAX_MOVE_RST;
    logic [SLOP_W-1:0] tap_slop    = TAP_SLOP_RST;
    logic [STEP_W-1:0] scroll_pitch = SCROLL_STEP_RST;
    logic [TAPT_W-1:0] tap_time    = TAP_TIME_RST;

    // tracking state
    zone_t                 act_zone    = ZONE_NONE;
    logic [COORD_BITS-1:0] last_x      = '0;
    logic [COORD_BITS-1:0] last_y      = '0;
    logic [COORD_BITS-1:0] start_x     = '0;
    logic [COORD_BITS-1:0] start_y     = '0;
    logic [TIME_W-1:0]     start_stamp = '0;
    int                    scroll_acc  = 0;
    logic                  moved       = 1'b0;

    assign s_req_type   = offered.req;
    assign s_touch_x    = offered.x;
    assign s_touch_y    = offered.y;
    assign s_touch_zone = offered.zone;
    assign s_time_ms    = offered.stamp;

    touch_gesture_to_mouse_reports #(
        .COORD_BITS         (COORD_BITS),
        .MAX_WHEEL_PER_ITEM (WHEEL_PER_ITEM)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_touch_x     (s_touch_x),
        .s_touch_y     (s_touch_y),
        .s_touch_zone  (s_touch_zone),
        .s_time_ms     (s_time_ms),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_report_kind (m_report_kind),
        .m_move_x      (m_move_x),
        .m_move_y      (m_move_y),
        .m_button_id   (m_button_id),
        .m_button_down (m_button_down),
        .m_wheel_dir   (m_wheel_dir),
        .m_last_of_run (m_last_of_run)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    function automatic report_t make_report(kind_t k, int mx, int my, logic [1:0] bid,
                                            logic down, logic signed [1:0] wheel);
        report_t r;
        r.kind  = k;
        r.mx    = mx[OUT_MOVE_W-1:0];
        r.my    = my[OUT_MOVE_W-1:0];
        r.bid   = bid;
        r.down  = down;
        r.wheel = wheel;
        r.last  = 1'b0;
        return r;
    endfunction

    // gain, truncation toward zero, then clamp to the step limit
    function automatic int scale_move(int d);
        int den;
        int v;
        int lim;
        den = (gain_den == '0) ? 1 : int'(gain_den);
        v   = d * int'(gain_num) / den;
        lim = int'(max_move);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    // updates the tracking state for one accepted sample and queues its reports
    task automatic track_touch(input touch_t t);
        report_t     run[$];
        zone_t       zone;
        int          dx;
        int          dy;
        int          ox;
        int          oy;
        int          pitch;
        int          acc;
        logic [31:0] elapsed;
        // out-of-range zone codes count as no zone
        zone = (t.zone > ZONE_LAST) ? ZONE_NONE : zone_t'(t.zone);
        case (t.req)
            REQ_PRESS: begin
                act_zone    = zone;
                last_x      = t.x;
                last_y      = t.y;
                start_x     = t.x;
                start_y     = t.y;
                start_stamp = t.stamp;
                scroll_acc  = 0;
                moved       = 1'b0;
                if (zone == ZONE_LEFT)
                    run.push_back(make_report(KIND_BUTTON, 0, 0, BTN_LEFT, 1'b1, WHEEL_NONE));
                else if (zone == ZONE_RIGHT)
                    run.push_back(make_report(KIND_BUTTON, 0, 0, BTN_RIGHT, 1'b1, WHEEL_NONE));
            end
            REQ_HELD: begin
                // nothing at all, not even the last position, without a zone
                if (act_zone != ZONE_NONE) begin
                    dx = int'(t.x) - int'(last_x);
                    dy = int'(t.y) - int'(last_y);
                    if (act_zone == ZONE_PAD) begin
                        if (dx != 0 || dy != 0)
                            run.push_back(make_report(KIND_MOVE, scale_move(dx), scale_move(dy),
                                                      BTN_NONE, 1'b0, WHEEL_NONE));
                        ox = int'(t.x) - int'(start_x);
                        oy = int'(t.y) - int'(start_y);
                        if (ox < 0) ox = -ox;
                        if (oy < 0) oy = -oy;
                        if (ox > int'(tap_slop) || oy > int'(tap_slop))
                            moved = 1'b1;
                    end else if (act_zone == ZONE_SCROLL) begin
                        pitch = (scroll_pitch == '0) ? 1 : int'(scroll_pitch);
                        acc   = scroll_acc + dy;
                        if (acc > ACC_MAX) acc = ACC_MAX;
                        if (acc < ACC_MIN) acc = ACC_MIN;
                        // finger travelling down the strip scrolls down
                        while (acc >= pitch && run.size() < WHEEL_CAP) begin
                            run.push_back(make_report(KIND_WHEEL, 0, 0, BTN_NONE, 1'b0,
                                                      WHEEL_DOWN));
                            acc -= pitch;
                        end
                        while (acc <= -pitch && run.size() < WHEEL_CAP) begin
                            run.push_back(make_report(KIND_WHEEL, 0, 0, BTN_NONE, 1'b0,
                                                      WHEEL_UP));
                            acc += pitch;
                        end
                        scroll_acc = acc;
                    end
                    last_x = t.x;
                    last_y = t.y;
                end
            end
            REQ_RELEASE: begin
                elapsed = t.stamp - start_stamp;
                if (act_zone == ZONE_PAD) begin
                    if (!moved && elapsed < {16'd0, tap_time})
                        run.push_back(make_report(KIND_CLICK, 0, 0, BTN_LEFT, 1'b0, WHEEL_NONE));
                end else if (act_zone == ZONE_LEFT) begin
                    run.push_back(make_report(KIND_BUTTON, 0, 0, BTN_LEFT, 1'b0, WHEEL_NONE));
                end else if (act_zone == ZONE_RIGHT) begin
                    run.push_back(make_report(KIND_BUTTON, 0, 0, BTN_RIGHT, 1'b0, WHEEL_NONE));
                end
                act_zone = ZONE_NONE;
            end
            default: begin
                // clear keeps positions and start time
                act_zone   = ZONE_NONE;
                scroll_acc = 0;
                moved      = 1'b0;
            end
        endcase
        if (run.size() != 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[i])
            report_q.push_back(run[i]);
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("%0t ns  MISMATCH %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("beat %0d %s: got %0d, expected %0d",
                                    beats_seen, name, got, want));
    endtask

    // predicts on every sample beat, compares every report beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                track_touch(offered);
            if (m_valid && m_ready) begin
                beats_seen++;
                if (report_q.size() == 0) begin
                    flag_mismatch($sformatf("beat %0d arrived with no report expected",
                                            beats_seen));
                end else begin
                    want_report = report_q.pop_front();
                    check_field("report_kind", m_report_kind, want_report.kind);
                    check_field("move_x", m_move_x, want_report.mx);
                    check_field("move_y", m_move_y, want_report.my);
                    check_field("button_id", m_button_id, want_report.bid);
                    check_field("button_down", m_button_down, want_report.down);
                    check_field("wheel_dir", m_wheel_dir, want_report.wheel);
                    check_field("last_of_run", m_last_of_run, want_report.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver and receiver, both move on the falling edge
    // ------------------------------------------------------------------------

    always @(posedge aclk)
        s_fire <= aresetn && s_valid && s_ready;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                offered <= sample_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_off_go && !hold_off_done) begin
            // long stall so the output register fills and s_ready drops
            hold_left     <= 400;
            hold_off_done <= 1'b1;
            m_ready       <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic push_touch(input req_t r, input int x, input int y, input int z,
                              input logic [31:0] stamp);
        touch_t t;
        t.req   = r;
        t.x     = x[COORD_BITS-1:0];
        t.y     = y[COORD_BITS-1:0];
        t.zone  = z[ZONE_W-1:0];
        t.stamp = stamp;
        sample_q.push_back(t);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_GAIN_NUM:    gain_num     = val[GAIN_W-1:0];
            CFG_GAIN_DEN:    gain_den     = val[GAIN_W-1:0];
            CFG_MAX_MOVE:    max_move     = val[MOVE_W-1:0];
            CFG_TAP_SLOP:    tap_slop     = val[SLOP_W-1:0];
            CFG_SCROLL_STEP: scroll_pitch = val[STEP_W-1:0];
            CFG_TAP_TIME:    tap_time     = val[TAPT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input int num, input int den, input int mmax, input int slop,
                            input int pitch, input int tap);
        write_reg(CFG_GAIN_NUM, num[CFG_DATA_W-1:0]);
        write_reg(CFG_GAIN_DEN, den[CFG_DATA_W-1:0]);
        write_reg(CFG_MAX_MOVE, mmax[CFG_DATA_W-1:0]);
        write_reg(CFG_TAP_SLOP, slop[CFG_DATA_W-1:0]);
        write_reg(CFG_SCROLL_STEP, pitch[CFG_DATA_W-1:0]);
        write_reg(CFG_TAP_TIME, tap[CFG_DATA_W-1:0]);
    endtask

    // waits for all samples and reports, then for the block to go quiet
    task automatic settle();
        while (sample_q.size() != 0 || s_valid || report_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // finger wander: mostly small steps, some large, a few jumps anywhere
    function automatic int wander(int p);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            p = p + int'($urandom_range(0, 40)) - 20;
        else if (r < 90)
            p = p + int'($urandom_range(0, 400)) - 200;
        else
            p = $urandom_range(0, 1023);
        if (p < 0) p = 0;
        if (p > 1023) p = 1023;
        return p;
    endfunction

    // press, a few held samples, then release or clear; some stray samples too
    task automatic queue_gestures(input int count);
        int          made;
        int          pick;
        int          holds;
        int          x;
        int          y;
        int          z;
        logic [31:0] clock_ms;
        logic [31:0] gap;
        made     = 0;
        clock_ms = $urandom;
        while (made < count) begin
            pick     = $urandom_range(0, 99);
            clock_ms = clock_ms + $urandom_range(1, 2000);
            if (pick < 8) begin
                push_touch(req_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
                           $urandom_range(0, 1023), $urandom_range(0, 7), $urandom);
                made++;
            end else begin
                if (pick < 45)      z = ZONE_PAD;
                else if (pick < 70) z = ZONE_SCROLL;
                else if (pick < 80) z = ZONE_LEFT;
                else if (pick < 90) z = ZONE_RIGHT;
                else                z = $urandom_range(0, 7);
                x = $urandom_range(0, 1023);
                y = $urandom_range(0, 1023);
                push_touch(REQ_PRESS, x, y, z, clock_ms);
                holds = $urandom_range(0, 6);
                repeat (holds) begin
                    x        = wander(x);
                    y        = wander(y);
                    clock_ms = clock_ms + $urandom_range(1, 40);
                    push_touch(REQ_HELD, x, y, $urandom_range(0, 7), clock_ms);
                end
                if ($urandom_range(0, 9) == 0) begin
                    push_touch(REQ_CLEAR, x, y, $urandom_range(0, 7), clock_ms);
                end else begin
                    pick = $urandom_range(0, 3);
                    if (pick < 2)
                        gap = $urandom_range(0, 300);
                    else if (pick == 2)
                        gap = {16'd0, tap_time} + $urandom_range(0, 4) - 2;
                    else
                        gap = $urandom;
                    push_touch(REQ_RELEASE, x, y, $urandom_range(0, 7), clock_ms + gap);
                    clock_ms = clock_ms + gap;
                end
                made += holds + 2;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed samples at reset register values
        // pad: full-scale moves clamp both ways, moved touch gives no click
        push_touch(REQ_PRESS, 0, 0, ZONE_PAD, 32'd0);
        push_touch(REQ_HELD, 1023, 1023, ZONE_PAD, 32'd5);
        push_touch(REQ_HELD, 0, 0, ZONE_NONE, 32'd7);
        push_touch(REQ_RELEASE, 0, 0, ZONE_PAD, 32'd8);
        // tap across the timestamp wrap, move right on the slop edge
        push_touch(REQ_PRESS, 500, 500, ZONE_PAD, 32'hFFFF_FFF0);
        push_touch(REQ_HELD, 503, 490, ZONE_PAD, 32'hFFFF_FFFF);
        push_touch(REQ_RELEASE, 503, 490, ZONE_PAD, 32'h0000_0010);
        // release exactly at the tap time, then one short of it
        push_touch(REQ_PRESS, 100, 100, ZONE_PAD, 32'd100);
        push_touch(REQ_RELEASE, 100, 100, ZONE_PAD, 32'd300);
        push_touch(REQ_PRESS, 100, 100, ZONE_PAD, 32'd1000);
        push_touch(REQ_RELEASE, 100, 100, ZONE_PAD, 32'd1199);
        // buttons, held on a button gives nothing
        push_touch(REQ_PRESS, 10, 10, ZONE_LEFT, 32'd2000);
        push_touch(REQ_HELD, 20, 20, ZONE_LEFT, 32'd2010);
        push_touch(REQ_RELEASE, 20, 20, ZONE_LEFT, 32'd2020);
        push_touch(REQ_PRESS, 1023, 1023, ZONE_RIGHT, 32'd3000);
        push_touch(REQ_RELEASE, 1023, 1023, ZONE_RIGHT, 32'd3001);
        // scroll: capped runs both ways with remainder kept, then clear
        push_touch(REQ_PRESS, 0, 0, ZONE_SCROLL, 32'd4000);
        push_touch(REQ_HELD, 0, 1023, ZONE_SCROLL, 32'd4010);
        push_touch(REQ_HELD, 0, 1023, ZONE_SCROLL, 32'd4020);
        push_touch(REQ_HELD, 0, 0, ZONE_SCROLL, 32'd4030);
        push_touch(REQ_CLEAR, 0, 0, ZONE_SCROLL, 32'd4040);
        // no zone tracked: held and release are ignored
        push_touch(REQ_HELD, 0, 500, ZONE_SCROLL, 32'd4050);
        push_touch(REQ_RELEASE, 0, 500, ZONE_PAD, 32'd4060);
        // zone code beyond the last one
        push_touch(REQ_PRESS, 300, 300, 7, 32'd5000);
        push_touch(REQ_RELEASE, 300, 300, 5, 32'd5001);
        settle();

        // low extremes
        set_regs(1, 16, 1, 0, 1, 1);
        queue_gestures(90);
        settle();

        // mid values
        set_regs(3, 2, 50, 20, 7, 500);
        queue_gestures(90);
        settle();

        // high extremes, sender now idles more than the receiver
        send_idle_pct = 81;
        recv_idle_pct = 19;
        set_regs(16, 1, 1023, 255, 255, 65535);
        queue_gestures(90);
        settle();

        // zero divisor, zero clamp, zero scroll step and zero tap time
        set_regs(31, 0, 0, 0, 0, 0);
        queue_gestures(80);
        settle();

        // random register values, no idling, one long receiver stall
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
        queue_gestures(100);
        repeat (20) @(posedge aclk);
        hold_off_go = 1'b1;
        settle();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
